// ===== rtl/rbhs_pkg.sv =====
// ----------------------------------------------------------------------------
// rbhs_pkg
// Shared widths, constants and register codes for the ring band HSV shader.
// ----------------------------------------------------------------------------
package rbhs_pkg;

  localparam int POS_FRAC_BITS    = 14;
  localparam int COLOUR_FRAC_BITS = 12;

  localparam int POS_W    = 16;
  localparam int COLOUR_W = 16;
  localparam int RANGE_CFG_W = 15;
  localparam int HUE_W    = 9;
  localparam int SAT_W    = 16;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // projection sum and divider widths
  localparam int PROD_W  = 2 * POS_W;
  localparam int PROJ_W  = ((POS_W + POS_FRAC_BITS > PROD_W) ?
                            (POS_W + POS_FRAC_BITS) : PROD_W) + 2;
  localparam int RANGE_W = RANGE_CFG_W + POS_FRAC_BITS;
  localparam int QUO_W   = 17;
  localparam int DIV_STAGES = QUO_W;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_COEF_X       = 3'd0,
    REG_COEF_Y       = 3'd1,
    REG_COEF_Z       = 3'd2,
    REG_PLANE_OFFSET = 3'd3,
    REG_BAND_RANGE   = 3'd4,
    REG_HUE_DEGREES  = 3'd5,
    REG_SATURATION   = 3'd6
  } cfg_reg_t;

endpackage

// ===== rtl/rbhs_if.sv =====
// ----------------------------------------------------------------------------
// rbhs_if
// Valid/ready channels of the ring band HSV shader: LED in, LED out, config.
// ----------------------------------------------------------------------------
interface rbhs_in_if import rbhs_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [POS_W-1:0]    pos_x;
  logic signed [POS_W-1:0]    pos_y;
  logic signed [POS_W-1:0]    pos_z;
  logic        [COLOUR_W-1:0] acc_red;
  logic        [COLOUR_W-1:0] acc_green;
  logic        [COLOUR_W-1:0] acc_blue;

  modport source (output valid, pos_x, pos_y, pos_z, acc_red, acc_green, acc_blue,
                  input ready);
  modport sink   (input valid, pos_x, pos_y, pos_z, acc_red, acc_green, acc_blue,
                  output ready);
endinterface

interface rbhs_out_if import rbhs_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [COLOUR_W-1:0] out_red;
  logic [COLOUR_W-1:0] out_green;
  logic [COLOUR_W-1:0] out_blue;
  logic                in_band;

  modport source (output valid, out_red, out_green, out_blue, in_band, input ready);
  modport sink   (input valid, out_red, out_green, out_blue, in_band, output ready);
endinterface

interface rbhs_cfg_if import rbhs_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/rbhs_div.sv =====
// ----------------------------------------------------------------------------
// rbhs_div
// Pipelined restoring divider, one quotient bit per stage, most significant
// first. Requires rem_in <= den_in; gives floor((rem_in << (QUO_W-1)) / den_in).
// ----------------------------------------------------------------------------
module rbhs_div import rbhs_pkg::*; (
  input  logic               clk,
  input  logic               en,
  input  logic [RANGE_W-1:0] rem_in,
  input  logic [RANGE_W-1:0] den_in,
  output logic [QUO_W-1:0]   quo
);

  logic [RANGE_W-1:0] rem_q [DIV_STAGES];
  logic [RANGE_W-1:0] den_q [DIV_STAGES];
  logic [QUO_W-1:0]   quo_q [DIV_STAGES];

  for (genvar g = 0; g < DIV_STAGES; g++) begin : g_step
    logic [RANGE_W:0]   trial;
    logic [RANGE_W-1:0] den;
    logic [QUO_W-1:0]   quo_prev;
    logic               ge;
    logic [RANGE_W:0]   diff;

    if (g == 0) begin : g_first
      assign trial    = {1'b0, rem_in};
      assign den      = den_in;
      assign quo_prev = '0;
    end else begin : g_rest
      assign trial    = {rem_q[g-1], 1'b0};
      assign den      = den_q[g-1];
      assign quo_prev = quo_q[g-1];
    end

    assign ge   = trial >= {1'b0, den};
    assign diff = trial - {1'b0, den};

    always_ff @(posedge clk) begin
      if (en) begin
        rem_q[g] <= ge ? diff[RANGE_W-1:0] : trial[RANGE_W-1:0];
        den_q[g] <= den;
        quo_q[g] <= {quo_prev[QUO_W-2:0], ge};
      end
    end
  end

  assign quo = quo_q[DIV_STAGES-1];

endmodule

// ===== rtl/ring_band_hsv_shader.sv =====
// ----------------------------------------------------------------------------
// ring_band_hsv_shader
// Lights LEDs near a configured plane with one HSV colour, added saturating
// to each LED's accumulated colour.
// ----------------------------------------------------------------------------
// One LED enters per clock for as long as led_out is taken. The pipeline is
// built around the 17-stage restoring divider that forms 1 - d/band_range,
// with four stages of projection ahead of it and nine stages of brightness,
// HSV and colour add behind. A stall on led_out holds the whole pipeline, so
// led_in.ready drops only while a finished result waits. Configuration writes
// are always taken and must happen with the pipeline empty.
module ring_band_hsv_shader import rbhs_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  rbhs_cfg_if.sink      cfg,
  rbhs_in_if.sink       led_in,
  rbhs_out_if.source    led_out
);

  localparam int PRE_ST  = 4;
  localparam int POST_ST = 9;
  localparam int N_ST    = PRE_ST + DIV_STAGES + POST_ST;

  localparam int V_W  = 18;
  localparam int M_W  = 2 * V_W;
  localparam int CH_W = V_W + 1;
  localparam int N_W  = 25;
  localparam int RECIP_SH = 30;
  localparam int COL_SH = 16 - COLOUR_FRAC_BITS;

  localparam logic [V_W-1:0]  GAIN_Q16  = V_W'(85197);
  localparam logic [M_W-1:0]  ROUND_Q16 = M_W'(32768);
  localparam logic [N_W-1:0]  RECIP_60  = N_W'(17895697);
  localparam logic [CH_W-1:0] COL_HALF  = (COL_SH == 0) ? '0 : CH_W'(1) << (COL_SH - 1);

  typedef enum logic [2:0] {
    SEC_RED_YEL = 3'd0,
    SEC_YEL_GRN = 3'd1,
    SEC_GRN_CYN = 3'd2,
    SEC_CYN_BLU = 3'd3,
    SEC_BLU_MAG = 3'd4,
    SEC_MAG_RED = 3'd5
  } sector_t;

  typedef struct packed {
    sector_t    sector;
    logic [5:0] k;
  } hue_sel_t;

  typedef struct packed {
    logic                lit;
    logic [COLOUR_W-1:0] acc_red;
    logic [COLOUR_W-1:0] acc_green;
    logic [COLOUR_W-1:0] acc_blue;
  } side_t;

  function automatic hue_sel_t hue_split(input logic [HUE_W-1:0] h);
    hue_sel_t         hs;
    logic [HUE_W-1:0] h2;
    priority if (h >= HUE_W'(480)) h2 = h - HUE_W'(480);
    else if (h >= HUE_W'(360))     h2 = h - HUE_W'(360);
    else if (h >= HUE_W'(240))     h2 = h - HUE_W'(240);
    else if (h >= HUE_W'(120))     h2 = h - HUE_W'(120);
    else                           h2 = h;
    hs.k = (h2 < HUE_W'(60)) ? h2[5:0] : 6'(HUE_W'(120) - h2);
    priority if (h >= HUE_W'(300)) hs.sector = SEC_MAG_RED;
    else if (h >= HUE_W'(240))     hs.sector = SEC_BLU_MAG;
    else if (h >= HUE_W'(180))     hs.sector = SEC_CYN_BLU;
    else if (h >= HUE_W'(120))     hs.sector = SEC_GRN_CYN;
    else if (h >= HUE_W'(60))      hs.sector = SEC_YEL_GRN;
    else                           hs.sector = SEC_RED_YEL;
    return hs;
  endfunction

  function automatic logic [V_W-1:0] mul_q16(input logic [V_W-1:0] a,
                                             input logic [V_W-1:0] b);
    logic [M_W-1:0] p;
    p = M_W'(a) * M_W'(b) + ROUND_Q16;
    return p[16 +: V_W];
  endfunction

  function automatic logic [CH_W-1:0] to_colour(input logic [CH_W-1:0] q16);
    return (q16 + COL_HALF) >> COL_SH;
  endfunction

  function automatic logic [COLOUR_W-1:0] sat_add(input logic [COLOUR_W-1:0] acc,
                                                  input logic [CH_W-1:0]     add);
    logic [CH_W:0] s;
    s = (CH_W+1)'(acc) + (CH_W+1)'(add);
    return (s > (CH_W+1)'({COLOUR_W{1'b1}})) ? {COLOUR_W{1'b1}} : s[COLOUR_W-1:0];
  endfunction

  // configuration registers
  logic signed [POS_W-1:0]       coef_x, coef_y, coef_z, plane_offset;
  logic        [RANGE_CFG_W-1:0] band_range;
  logic        [HUE_W-1:0]       hue_degrees;
  logic        [SAT_W-1:0]       saturation;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      coef_x       <= POS_W'(16384);
      coef_y       <= '0;
      coef_z       <= '0;
      plane_offset <= '0;
      band_range   <= RANGE_CFG_W'(3277);
      hue_degrees  <= '0;
      saturation   <= SAT_W'(45875);
    end else if (cfg.valid) begin
      unique case (cfg_reg_t'(cfg.index))
        REG_COEF_X:       coef_x       <= cfg.data;
        REG_COEF_Y:       coef_y       <= cfg.data;
        REG_COEF_Z:       coef_z       <= cfg.data;
        REG_PLANE_OFFSET: plane_offset <= cfg.data;
        REG_BAND_RANGE:   band_range   <= cfg.data[RANGE_CFG_W-1:0];
        REG_HUE_DEGREES:  hue_degrees  <= cfg.data[HUE_W-1:0];
        REG_SATURATION:   saturation   <= cfg.data;
        default: ;
      endcase
    end
  end

  hue_sel_t hue_sel;
  assign hue_sel = hue_split(hue_degrees);

  logic [PROJ_W-1:0] range_ext;
  assign range_ext = PROJ_W'(band_range) << POS_FRAC_BITS;

  // pipeline control: every stage moves together
  logic [N_ST-1:0] vld;
  logic            adv;

  assign adv          = !vld[N_ST-1] || led_out.ready;
  assign led_in.ready = adv;
  assign led_out.valid = vld[N_ST-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[N_ST-2:0], led_in.valid};
    end
  end

  // sideband: accumulated colour and the in-band flag
  side_t side [N_ST-1];

  // projection
  logic signed [PROD_W-1:0] p_x, p_y, p_z;
  logic signed [PROJ_W-1:0] ofs;
  logic signed [PROJ_W-1:0] proj;
  logic        [PROJ_W-1:0] proj_mag;
  logic                     lit;
  logic        [RANGE_W-1:0] div_rem, div_den;
  logic        [PROJ_W-1:0] diff;

  assign lit  = proj_mag < range_ext;
  assign diff = range_ext - proj_mag;

  always_ff @(posedge clk) begin
    if (adv) begin
      p_x      <= PROD_W'(coef_x) * PROD_W'(led_in.pos_x);
      p_y      <= PROD_W'(coef_y) * PROD_W'(led_in.pos_y);
      p_z      <= PROD_W'(coef_z) * PROD_W'(led_in.pos_z);
      ofs      <= PROJ_W'(plane_offset) <<< POS_FRAC_BITS;
      proj     <= PROJ_W'(p_x) + PROJ_W'(p_y) + PROJ_W'(p_z) + ofs;
      proj_mag <= proj[PROJ_W-1] ? PROJ_W'(-proj) : PROJ_W'(proj);
      div_rem  <= lit ? diff[RANGE_W-1:0] : '0;
      div_den  <= range_ext[RANGE_W-1:0];
      for (int i = 0; i < N_ST - 1; i++) begin
        if (i == 0) begin
          side[i] <= '{lit: 1'b0, acc_red: led_in.acc_red,
                       acc_green: led_in.acc_green, acc_blue: led_in.acc_blue};
        end else if (i == PRE_ST - 1) begin
          side[i] <= '{lit: lit, acc_red: side[i-1].acc_red,
                       acc_green: side[i-1].acc_green, acc_blue: side[i-1].acc_blue};
        end else begin
          side[i] <= side[i-1];
        end
      end
    end
  end

  // t = 1 - d/R in Q.16
  logic [QUO_W-1:0] t_q16;

  rbhs_div u_div (
    .clk    (clk),
    .en     (adv),
    .rem_in (div_rem),
    .den_in (div_den),
    .quo    (t_q16)
  );

  // brightness, chroma, hue mix
  logic [V_W-1:0] u5, u2_6, v7;
  logic [V_W-1:0] v8, c8;
  logic [V_W-1:0] v9, c9;
  logic [N_W-1:0] n9;
  logic [V_W-1:0] v10, c10, q10;
  logic [N_W-1:0] n10;
  logic [V_W-1:0] v11, c11, x11;
  logic [CH_W-1:0] r12, g12, b12;

  logic [2*N_W-1:0] recip_prod;
  logic [N_W-1:0]   q60, rem60;
  logic [V_W-1:0]   m11;
  logic [V_W-1:0]   r_sel, g_sel, b_sel;

  assign recip_prod = (2*N_W)'(n9) * (2*N_W)'(RECIP_60);
  assign q60        = (N_W'(q10) << 6) - (N_W'(q10) << 2);
  assign rem60      = n10 - q60;
  assign m11        = v11 - c11;

  always_comb begin
    unique case (hue_sel.sector)
      SEC_RED_YEL: begin r_sel = c11; g_sel = x11; b_sel = '0;  end
      SEC_YEL_GRN: begin r_sel = x11; g_sel = c11; b_sel = '0;  end
      SEC_GRN_CYN: begin r_sel = '0;  g_sel = c11; b_sel = x11; end
      SEC_CYN_BLU: begin r_sel = '0;  g_sel = x11; b_sel = c11; end
      SEC_BLU_MAG: begin r_sel = x11; g_sel = '0;  b_sel = c11; end
      default:     begin r_sel = c11; g_sel = '0;  b_sel = x11; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      u5   <= mul_q16(V_W'(t_q16), GAIN_Q16);
      u2_6 <= mul_q16(u5, u5);
      v7   <= mul_q16(u2_6, u2_6);
      v8   <= v7;
      c8   <= mul_q16(V_W'(saturation), v7);
      v9   <= v8;
      c9   <= c8;
      n9   <= N_W'(c8) * N_W'(hue_sel.k) + N_W'(30);
      v10  <= v9;
      c10  <= c9;
      n10  <= n9;
      q10  <= recip_prod[RECIP_SH +: V_W];
      v11  <= v10;
      c11  <= c10;
      x11  <= (rem60 >= N_W'(60)) ? q10 + V_W'(1) : q10;
      r12  <= to_colour(CH_W'(r_sel) + CH_W'(m11));
      g12  <= to_colour(CH_W'(g_sel) + CH_W'(m11));
      b12  <= to_colour(CH_W'(b_sel) + CH_W'(m11));
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (adv) begin
      led_out.in_band <= side[N_ST-2].lit;
      if (side[N_ST-2].lit) begin
        led_out.out_red   <= sat_add(side[N_ST-2].acc_red, r12);
        led_out.out_green <= sat_add(side[N_ST-2].acc_green, g12);
        led_out.out_blue  <= sat_add(side[N_ST-2].acc_blue, b12);
      end else begin
        led_out.out_red   <= side[N_ST-2].acc_red;
        led_out.out_green <= side[N_ST-2].acc_green;
        led_out.out_blue  <= side[N_ST-2].acc_blue;
      end
    end
  end

endmodule

// ===== rtl/rbhs_checker.sv =====
// ----------------------------------------------------------------------------
// rbhs_checker
// Port-level checks on the ring band HSV shader, bound to the top level.
// ----------------------------------------------------------------------------
module rbhs_checker import rbhs_pkg::*; (
  input logic                clk,
  input logic                rst,
  input logic                cfg_ready,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input logic [COLOUR_W-1:0] out_red,
  input logic [COLOUR_W-1:0] out_green,
  input logic [COLOUR_W-1:0] out_blue,
  input logic                in_band
);

  // nothing leaves straight after reset
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result offered right after reset");

  // an empty output stage never blocks a new request
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with no result waiting");

  // a waiting result holds the input side as well
  a_stall_holds_input: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !in_ready)
    else $error("request taken while result stalled");

  a_cfg_always_ready: assert property (@(posedge clk) disable iff (rst)
    cfg_ready)
    else $error("config write refused");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_red) && $stable(out_green)
                                && $stable(out_blue) && $stable(in_band))
    else $error("stalled result changed");

endmodule

bind ring_band_hsv_shader rbhs_checker u_rbhs_checker (
  .clk       (clk),
  .rst       (rst),
  .cfg_ready (cfg.ready),
  .in_ready  (led_in.ready),
  .out_valid (led_out.valid),
  .out_ready (led_out.ready),
  .out_red   (led_out.out_red),
  .out_green (led_out.out_green),
  .out_blue  (led_out.out_blue),
  .in_band   (led_out.in_band)
);
